// File: rtl/rrht_pkg.sv
// Package for the revoke record hash table: sizes, opcodes, sequencer states
// and the bucket hash. No dependencies.
package rrht_pkg;

    localparam int BUCKET_BITS = 8;
    localparam int WAYS        = 4;
    localparam int BUCKETS     = 1 << BUCKET_BITS;
    localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_BITS    = BUCKET_BITS + 1;
    localparam int SLOT_BITS   = ROW_BITS + WAY_BITS;
    localparam int CNT_BITS    = ROW_BITS + 1;
    localparam int SHIFT_A     = BUCKET_BITS - 6;
    localparam int SHIFT_B     = 13;
    localparam int SHIFT_C     = BUCKET_BITS - 12;

    typedef enum logic [2:0] {
        OP_REVOKE  = 3'd0,
        OP_RECOVER = 3'd1,
        OP_TEST    = 3'd2,
        OP_CANCEL  = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_SWITCH  = 3'd5,
        OP_DRAIN   = 3'd6
    } t_opcode;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_LOOK, S_CMP, S_CLR, S_DRD, S_DCK, S_DOUT, S_RES
    } t_state;

    // Left shift by k, right shift by -k when k is negative.
    function automatic logic [31:0] shift_signed(input logic [31:0] v, input int k);
        logic [31:0] r;
        if (k >= 0) begin
            r = (k < 32) ? (v << k) : 32'd0;
        end else begin
            r = (-k < 32) ? (v >> (-k)) : 32'd0;
        end
        return r;
    endfunction

    function automatic logic [BUCKET_BITS-1:0] bucket_of(input logic [31:0] b);
        logic [31:0] h;
        h = shift_signed(b, SHIFT_A) ^ (b >> SHIFT_B) ^ shift_signed(b, SHIFT_C);
        return h[BUCKET_BITS-1:0];
    endfunction

    // Wrap-aware "a is later than b".
    function automatic logic seq_later(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

endpackage

// File: rtl/rrht_if.sv
// Valid/ready channel interfaces for the revoke record hash table.
// Depends on nothing but the field widths of the block.
interface rrht_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] block_number;
    logic [31:0] sequence_req;
    modport source (output valid, output opcode, output block_number,
                    output sequence_req, input ready);
    modport sink   (input valid, input opcode, input block_number,
                    input sequence_req, output ready);
endinterface

interface rrht_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic        hit;
    logic [31:0] out_block;
    logic [31:0] out_sequence;
    modport source (output valid, output status, output hit, output out_block,
                    output out_sequence, input ready);
    modport sink   (input valid, input status, input hit, input out_block,
                    input out_sequence, output ready);
endinterface

// File: rtl/revoke_record_hash_table_unit.sv
// Revoke record hash table top level: sequencer, row valid memory and
// per-slot block and sequence memories. Depends on rrht_pkg and rrht_if.
// Lookup ops scan the ways of one bucket and stop early on a hit; clear and switch
// walk every bucket of one bank; drain makes one row read and check per bucket.
// Only one transaction is in flight: the next is accepted only back in S_IDLE.
// Reset: synchronous, active low; a clearing pass empties the valid rows of both banks first.
module revoke_record_hash_table_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrht_in_if.sink    i_in,
    rrht_out_if.source o_out
);

    localparam int BB = rrht_pkg::BUCKET_BITS;
    localparam int WB = rrht_pkg::WAY_BITS;
    localparam int RB = rrht_pkg::ROW_BITS;
    localparam int SB = rrht_pkg::SLOT_BITS;
    localparam int CB = rrht_pkg::CNT_BITS;
    localparam int NW = rrht_pkg::WAYS;

    // Valid bits per bucket row, and the record payload per slot.
    logic [NW-1:0] vmem [2*rrht_pkg::BUCKETS];
    logic [31:0]   bmem [1 << SB];
    logic [31:0]   smem [1 << SB];

    rrht_pkg::t_state  r_state, n_state;
    rrht_pkg::t_opcode r_op, n_op;
    logic [31:0]   r_blk, n_blk, r_seq, n_seq;
    logic          r_bank, n_bank;
    logic [BB-1:0] r_cur_bkt, n_cur_bkt, r_bkt, n_bkt;
    logic [WB-1:0] r_cur_way, n_cur_way, r_way, n_way;
    logic [CB-1:0] r_cnt, n_cnt;
    logic          r_pst, n_pst, r_phit, n_phit;
    logic [31:0]   r_pob, n_pob, r_pos, n_pos;
    logic          r_ovalid, n_ovalid, r_ost, n_ost, r_ohit, n_ohit;
    logic [31:0]   r_oblk, n_oblk, r_oseq, n_oseq;

    // Memory read data registers.
    logic [NW-1:0] r_vrd;
    logic [31:0]   r_brd, r_srd;

    // Memory port controls.
    logic          v_re, v_we, e_re, e_we;
    logic [RB-1:0] v_raddr, v_waddr;
    logic [NW-1:0] v_wdata;
    logic [SB-1:0] e_raddr, e_waddr;
    logic          e_wb;
    logic [31:0]   e_bdata, e_sdata;

    // Match and free-way search over the current row.
    logic          way_hit, later, free_any, dr_any;
    logic [WB-1:0] free_way, dr_way;
    logic [NW-1:0] dr_mask;

    assign way_hit = r_vrd[r_way] && (r_brd == r_blk);
    assign later   = rrht_pkg::seq_later(r_seq, r_srd);

    always_comb begin
        free_any = 1'b0;
        free_way = '0;
        for (int w = NW - 1; w >= 0; w--) begin
            if (!r_vrd[w]) begin
                free_any = 1'b1;
                free_way = WB'(w);
            end
        end
    end

    // Drain window: from the cursor way on the first visit, below it on the
    // wrap-around visit, everything in between.
    always_comb begin
        dr_any = 1'b0;
        dr_way = '0;
        for (int w = 0; w < NW; w++) begin
            if (r_cnt == '0) begin
                dr_mask[w] = r_vrd[w] && (WB'(w) >= r_cur_way);
            end else if (r_cnt == CB'(rrht_pkg::BUCKETS)) begin
                dr_mask[w] = r_vrd[w] && (WB'(w) < r_cur_way);
            end else begin
                dr_mask[w] = r_vrd[w];
            end
        end
        for (int w = NW - 1; w >= 0; w--) begin
            if (dr_mask[w]) begin
                dr_any = 1'b1;
                dr_way = WB'(w);
            end
        end
    end

    assign i_in.ready         = (r_state == rrht_pkg::S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.status       = r_ost;
    assign o_out.hit          = r_ohit;
    assign o_out.out_block    = r_oblk;
    assign o_out.out_sequence = r_oseq;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_blk     = r_blk;
        n_seq     = r_seq;
        n_bank    = r_bank;
        n_cur_bkt = r_cur_bkt;
        n_cur_way = r_cur_way;
        n_bkt     = r_bkt;
        n_way     = r_way;
        n_cnt     = r_cnt;
        n_pst     = r_pst;
        n_phit    = r_phit;
        n_pob     = r_pob;
        n_pos     = r_pos;
        n_ovalid  = r_ovalid;
        n_ost     = r_ost;
        n_ohit    = r_ohit;
        n_oblk    = r_oblk;
        n_oseq    = r_oseq;
        v_re      = 1'b0;
        v_raddr   = {r_bank, r_bkt};
        v_we      = 1'b0;
        v_waddr   = {r_bank, r_bkt};
        v_wdata   = '0;
        e_re      = 1'b0;
        e_raddr   = {r_bank, r_bkt, r_way};
        e_we      = 1'b0;
        e_wb      = 1'b0;
        e_waddr   = {r_bank, r_bkt, r_way};
        e_bdata   = r_blk;
        e_sdata   = r_seq;

        // Drop the result once it is taken.
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            rrht_pkg::S_INIT: begin
                v_we    = 1'b1;
                v_waddr = r_cnt[RB-1:0];
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt[RB-1:0] == {RB{1'b1}}) begin
                    n_cnt   = '0;
                    n_state = rrht_pkg::S_IDLE;
                end
            end
            rrht_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_op   = rrht_pkg::t_opcode'(i_in.opcode);
                    n_blk  = i_in.block_number;
                    n_seq  = i_in.sequence_req;
                    n_pst  = 1'b0;
                    n_phit = 1'b0;
                    n_pob  = '0;
                    n_pos  = '0;
                    n_cnt  = '0;
                    case (i_in.opcode)
                        rrht_pkg::OP_REVOKE, rrht_pkg::OP_RECOVER,
                        rrht_pkg::OP_TEST, rrht_pkg::OP_CANCEL: begin
                            n_bkt   = rrht_pkg::bucket_of(i_in.block_number);
                            n_state = rrht_pkg::S_LOOK;
                        end
                        rrht_pkg::OP_CLEAR: begin
                            n_bkt   = '0;
                            n_state = rrht_pkg::S_CLR;
                        end
                        rrht_pkg::OP_SWITCH: begin
                            n_bank    = ~r_bank;
                            n_cur_bkt = '0;
                            n_cur_way = '0;
                            n_bkt     = '0;
                            n_state   = rrht_pkg::S_CLR;
                        end
                        rrht_pkg::OP_DRAIN: begin
                            n_bkt   = r_cur_bkt;
                            n_state = rrht_pkg::S_DRD;
                        end
                        default: n_state = rrht_pkg::S_RES;
                    endcase
                end
            end
            rrht_pkg::S_LOOK: begin
                // Fetch the row valid bits and way zero of the bucket.
                v_re    = 1'b1;
                e_re    = 1'b1;
                e_raddr = {r_bank, r_bkt, WB'(0)};
                n_way   = '0;
                n_state = rrht_pkg::S_CMP;
            end
            rrht_pkg::S_CMP: begin
                if (way_hit) begin
                    n_state = rrht_pkg::S_RES;
                    case (r_op)
                        rrht_pkg::OP_REVOKE: e_we = 1'b1;
                        rrht_pkg::OP_RECOVER: e_we = later;
                        rrht_pkg::OP_TEST: n_phit = !later;
                        rrht_pkg::OP_CANCEL: begin
                            v_we    = 1'b1;
                            v_wdata = r_vrd & ~(NW'(1) << r_way);
                            n_phit  = 1'b1;
                        end
                        default: ;
                    endcase
                end else if (r_way != WB'(NW - 1)) begin
                    // Advance to the next way.
                    n_way   = r_way + 1'b1;
                    e_re    = 1'b1;
                    e_raddr = {r_bank, r_bkt, r_way + 1'b1};
                end else begin
                    n_state = rrht_pkg::S_RES;
                    if (r_op == rrht_pkg::OP_REVOKE || r_op == rrht_pkg::OP_RECOVER) begin
                        if (free_any) begin
                            v_we    = 1'b1;
                            v_wdata = r_vrd | (NW'(1) << free_way);
                            e_we    = 1'b1;
                            e_wb    = 1'b1;
                            e_waddr = {r_bank, r_bkt, free_way};
                        end else begin
                            n_pst = 1'b1;
                        end
                    end
                end
            end
            rrht_pkg::S_CLR: begin
                v_we  = 1'b1;
                n_bkt = r_bkt + 1'b1;
                if (r_bkt == {BB{1'b1}}) begin
                    n_state = rrht_pkg::S_RES;
                end
            end
            rrht_pkg::S_DRD: begin
                v_re    = 1'b1;
                v_raddr = {~r_bank, r_bkt};
                n_state = rrht_pkg::S_DCK;
            end
            rrht_pkg::S_DCK: begin
                if (dr_any) begin
                    // Pop the record and leave the cursor at its slot.
                    e_re      = 1'b1;
                    e_raddr   = {~r_bank, r_bkt, dr_way};
                    v_we      = 1'b1;
                    v_waddr   = {~r_bank, r_bkt};
                    v_wdata   = r_vrd & ~(NW'(1) << dr_way);
                    n_cur_bkt = r_bkt;
                    n_cur_way = dr_way;
                    n_phit    = 1'b1;
                    n_state   = rrht_pkg::S_DOUT;
                end else if (r_cnt == CB'(rrht_pkg::BUCKETS)) begin
                    n_state = rrht_pkg::S_RES;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_bkt   = r_bkt + 1'b1;
                    n_state = rrht_pkg::S_DRD;
                end
            end
            rrht_pkg::S_DOUT: begin
                n_pob   = r_brd;
                n_pos   = r_srd;
                n_state = rrht_pkg::S_RES;
            end
            rrht_pkg::S_RES: begin
                // Hold until the output register is free.
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_pst;
                    n_ohit   = r_phit;
                    n_oblk   = r_pob;
                    n_oseq   = r_pos;
                    n_state  = rrht_pkg::S_IDLE;
                end
            end
            default: n_state = rrht_pkg::S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rrht_pkg::S_INIT;
            r_bank    <= 1'b1;
            r_cur_bkt <= '0;
            r_cur_way <= '0;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bank    <= n_bank;
            r_cur_bkt <= n_cur_bkt;
            r_cur_way <= n_cur_way;
            r_cnt     <= n_cnt;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_blk  <= n_blk;
        r_seq  <= n_seq;
        r_bkt  <= n_bkt;
        r_way  <= n_way;
        r_pst  <= n_pst;
        r_phit <= n_phit;
        r_pob  <= n_pob;
        r_pos  <= n_pos;
        r_ost  <= n_ost;
        r_ohit <= n_ohit;
        r_oblk <= n_oblk;
        r_oseq <= n_oseq;
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            vmem[v_waddr] <= v_wdata;
        end
        if (v_re) begin
            r_vrd <= vmem[v_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            smem[e_waddr] <= e_sdata;
        end
        if (e_we && e_wb) begin
            bmem[e_waddr] <= e_bdata;
        end
        if (e_re) begin
            r_brd <= bmem[e_raddr];
            r_srd <= smem[e_raddr];
        end
    end

endmodule
